// ===== hw/rtl/backward_lz_decompressor_defines.svh =====
// assertion macros for the backward lz decompressor
`ifndef BACKWARD_LZ_DECOMPRESSOR_DEFINES_SVH
`define BACKWARD_LZ_DECOMPRESSOR_DEFINES_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define BLZ_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("blz implication check failed");
// next-cycle implication
`define BLZ_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("blz next-cycle check failed");
`else
`define BLZ_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define BLZ_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== hw/rtl/blz_pkg.sv =====
package blz_pkg;

    typedef logic [7:0] t_byte;

    localparam int PROD_W = 13;
    localparam int DIST_W = 13;
    localparam int CNT_W  = 5;

    localparam logic [PROD_W-1:0] PRODUCED_MAX = 13'h1FFF;
    localparam logic [DIST_W-1:0] DIST_BIAS    = 13'd3;
    localparam logic [CNT_W-1:0]  LEN_BIAS     = 5'd3;
    localparam logic [3:0]        FLAG_TOKENS  = 4'd8;

    typedef enum logic [1:0] {
        PH_FLAG,
        PH_TOKEN,
        PH_REF_LOW
    } t_phase;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_COPY_RD,
        ST_COPY_WR
    } t_state;

endpackage

// ===== hw/rtl/blz_if.sv =====
interface blz_in_if import blz_pkg::*;;
    logic  valid;
    logic  ready;
    t_byte in_byte;
    logic  final_byte;

    modport source (output valid, output in_byte, output final_byte, input ready);
    modport sink   (input valid, input in_byte, input final_byte, output ready);
endinterface

interface blz_out_if import blz_pkg::*;;
    logic  valid;
    logic  ready;
    t_byte out_byte;
    logic  run_last;
    logic  stream_done;

    modport source (output valid, output out_byte, output run_last, output stream_done,
                    input ready);
    modport sink   (input valid, input out_byte, input run_last, input stream_done,
                    output ready);
endinterface

// ===== hw/rtl/blz_ram.sv =====
module blz_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8192
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/backward_lz_decompressor.sv =====
// backward lz77 decoder
// i_in carries compressed bytes, last byte of the image first; final_byte marks the
// last byte of a stream. o_out carries decoded bytes in reverse order, run_last on
// the last byte caused by one request and stream_done when that byte ends the stream.
// handling of each input request:
//   flag byte or reference high byte: accepted, no output
//   literal byte: output register loaded at the accept edge
//   reference low byte: accepted, then the first history read, then one copied
//   byte per cycle (3..18) while o_out does not stall, through the single read
//   port of the history memory; input is held off until the last copied byte
//   is out.
// a one-entry output register sits between decoder and receiver; a stalled
// receiver freezes the copy sequencer and blocks literal requests, while
// flag bytes and both reference bytes are still taken.
// reset clears the control state only; the history memory is not cleared, and
// references reaching beyond this stream's output produce zero bytes, so no
// unwritten entry is ever used.
`include "backward_lz_decompressor_defines.svh"

module backward_lz_decompressor import blz_pkg::*; #(
    parameter int WINDOW_DEPTH = 8192
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    blz_in_if.sink    i_in,
    blz_out_if.source o_out
);

    localparam int AW = $clog2(WINDOW_DEPTH);
    localparam logic [AW-1:0] LAST_POS = AW'(WINDOW_DEPTH - 1);

    t_state            r_state, n_state;
    t_phase            r_phase, n_phase;
    t_byte             r_flag_bits, n_flag_bits;
    logic [3:0]        r_bits_left, n_bits_left;
    t_byte             r_token_high, n_token_high;
    logic [PROD_W-1:0] r_produced, n_produced;
    logic [AW-1:0]     r_wp, n_wp;
    logic [AW-1:0]     r_rd_ptr, n_rd_ptr;
    logic [DIST_W-1:0] r_dist, n_dist;
    logic [CNT_W-1:0]  r_count, n_count;
    logic              r_fin, n_fin;
    logic              r_src_zero, n_src_zero;
    logic              r_out_valid, n_out_valid;
    t_byte             r_out_byte, n_out_byte;
    logic              r_out_last, n_out_last;
    logic              r_out_done, n_out_done;

    logic              slot_free;
    logic              is_literal;
    logic              in_ready;
    logic              in_acc;
    logic              copy_step;
    logic              copy_end;
    logic              ram_re;
    logic              ram_we;
    logic [AW-1:0]     ram_raddr;
    t_byte             ram_wdata;
    t_byte             ram_rdata;
    t_byte             copy_byte;
    logic [PROD_W-1:0] prod_inc;
    logic [AW-1:0]     wp_inc;
    logic [AW-1:0]     rd_inc;
    logic [AW:0]       base_diff;
    logic [AW-1:0]     base_addr;
    logic [3:0]        bits_dec;

    blz_ram #(
        .WIDTH (8),
        .DEPTH (WINDOW_DEPTH)
    ) u_history (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_wp),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign slot_free  = !r_out_valid || o_out.ready;
    assign is_literal = (r_phase == PH_TOKEN) && !r_flag_bits[7];
    assign in_acc     = i_in.valid && in_ready;
    assign copy_end   = copy_step && (r_count == CNT_W'(1));
    assign copy_byte  = r_src_zero ? '0 : ram_rdata;
    assign ram_wdata  = (r_state == ST_IDLE) ? i_in.in_byte : copy_byte;

    assign prod_inc = (r_produced == PRODUCED_MAX) ? r_produced : r_produced + 1'b1;
    assign wp_inc   = (r_wp == LAST_POS) ? '0 : r_wp + 1'b1;
    assign rd_inc   = (r_rd_ptr == LAST_POS) ? '0 : r_rd_ptr + 1'b1;
    assign bits_dec = (r_bits_left != '0) ? r_bits_left - 1'b1 : r_bits_left;

    // source slot of the first copied byte, wrapped into the ring
    assign base_diff = {1'b0, r_wp} - (AW+1)'(r_dist);
    assign base_addr = base_diff[AW] ? AW'(base_diff + (AW+1)'(WINDOW_DEPTH))
                                     : base_diff[AW-1:0];

    assign ram_raddr = (r_state == ST_COPY_RD) ? base_addr : rd_inc;

    // sequencer outputs
    always_comb begin
        in_ready  = 1'b0;
        copy_step = 1'b0;
        ram_re    = 1'b0;
        ram_we    = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                in_ready = slot_free || !is_literal;
                ram_we   = in_acc && is_literal;
            end
            ST_COPY_RD: begin
                ram_re = 1'b1;
            end
            ST_COPY_WR: begin
                copy_step = slot_free;
                ram_we    = slot_free;
                ram_re    = slot_free && (r_count != CNT_W'(1));
            end
            default: begin
                in_ready = 1'b0;
            end
        endcase
    end

    // sequencer next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc && (r_phase == PH_REF_LOW)) begin
                    n_state = ST_COPY_RD;
                end
            end
            ST_COPY_RD: begin
                n_state = ST_COPY_WR;
            end
            ST_COPY_WR: begin
                if (copy_end) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_phase      = r_phase;
        n_flag_bits  = r_flag_bits;
        n_bits_left  = r_bits_left;
        n_token_high = r_token_high;
        n_produced   = r_produced;
        n_wp         = r_wp;
        n_rd_ptr     = r_rd_ptr;
        n_dist       = r_dist;
        n_count      = r_count;
        n_fin        = r_fin;
        n_src_zero   = r_src_zero;
        n_out_valid  = r_out_valid && !o_out.ready;
        n_out_byte   = r_out_byte;
        n_out_last   = r_out_last;
        n_out_done   = r_out_done;

        if (ram_we) begin
            n_wp       = wp_inc;
            n_produced = prod_inc;
        end

        if (in_acc) begin
            case (r_phase)
                PH_FLAG: begin
                    n_flag_bits = i_in.in_byte;
                    n_bits_left = FLAG_TOKENS;
                    n_phase     = PH_TOKEN;
                end
                PH_TOKEN: begin
                    if (r_flag_bits[7]) begin
                        n_token_high = i_in.in_byte;
                        n_phase      = PH_REF_LOW;
                    end else begin
                        n_out_valid = 1'b1;
                        n_out_byte  = i_in.in_byte;
                        n_out_last  = 1'b1;
                        n_out_done  = i_in.final_byte;
                        n_flag_bits = {r_flag_bits[6:0], 1'b0};
                        n_bits_left = bits_dec;
                        n_phase     = (bits_dec != '0) ? PH_TOKEN : PH_FLAG;
                    end
                end
                PH_REF_LOW: begin
                    n_dist  = DIST_W'({r_token_high[3:0], i_in.in_byte}) + DIST_BIAS;
                    n_count = CNT_W'(r_token_high[7:4]) + LEN_BIAS;
                    n_fin   = i_in.final_byte;
                end
                default: begin
                    n_phase = PH_FLAG;
                end
            endcase
            // stream end on anything but a reference low byte takes effect now
            if (i_in.final_byte && (r_phase != PH_REF_LOW)) begin
                n_phase      = PH_FLAG;
                n_bits_left  = '0;
                n_flag_bits  = '0;
                n_produced   = '0;
                n_token_high = '0;
            end
        end

        if (r_state == ST_COPY_RD) begin
            n_rd_ptr   = base_addr;
            n_src_zero = r_dist > r_produced;
        end

        if (copy_step) begin
            n_rd_ptr    = rd_inc;
            n_src_zero  = r_dist > prod_inc;
            n_count     = r_count - 1'b1;
            n_out_valid = 1'b1;
            n_out_byte  = copy_byte;
            n_out_last  = copy_end;
            n_out_done  = copy_end && r_fin;
        end

        if (copy_end) begin
            n_flag_bits = {r_flag_bits[6:0], 1'b0};
            n_bits_left = bits_dec;
            n_phase     = (bits_dec != '0) ? PH_TOKEN : PH_FLAG;
            if (r_fin) begin
                n_phase      = PH_FLAG;
                n_bits_left  = '0;
                n_flag_bits  = '0;
                n_produced   = '0;
                n_token_high = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_phase      <= PH_FLAG;
            r_flag_bits  <= '0;
            r_bits_left  <= '0;
            r_token_high <= '0;
            r_produced   <= '0;
            r_wp         <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_phase      <= n_phase;
            r_flag_bits  <= n_flag_bits;
            r_bits_left  <= n_bits_left;
            r_token_high <= n_token_high;
            r_produced   <= n_produced;
            r_wp         <= n_wp;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_ptr   <= n_rd_ptr;
        r_dist     <= n_dist;
        r_count    <= n_count;
        r_fin      <= n_fin;
        r_src_zero <= n_src_zero;
        r_out_byte <= n_out_byte;
        r_out_last <= n_out_last;
        r_out_done <= n_out_done;
    end

    assign i_in.ready        = in_ready;
    assign o_out.valid       = r_out_valid;
    assign o_out.out_byte    = r_out_byte;
    assign o_out.run_last    = r_out_last;
    assign o_out.stream_done = r_out_done;

    `BLZ_ASSERT_IMP(a_busy_blocks_input, i_clk, i_rst_n, r_state != ST_IDLE, !i_in.ready)
    `BLZ_ASSERT_IMP(a_write_needs_slot, i_clk, i_rst_n, ram_we, slot_free)
    `BLZ_ASSERT_NXT(a_ref_starts_copy, i_clk, i_rst_n, in_acc && r_phase == PH_REF_LOW, r_state == ST_COPY_RD)
    `BLZ_ASSERT_IMP(a_copy_count_live, i_clk, i_rst_n, r_state == ST_COPY_WR, r_count != '0)

endmodule

// ===== tb/tb_backward_lz_decompressor.sv =====
`timescale 1ns / 100ps

module tb_backward_lz_decompressor;
    import blz_pkg::*;

    localparam int WINDOW       = 8192;
    localparam int HIST_AW      = $clog2(WINDOW);
    localparam int LIMIT_CYCLES = 400000;
    localparam int RANDOM_BYTES = 350;
    localparam int LONG_HOLD    = 300;

    typedef struct {
        t_byte data;
        logic  fin;
        logic  wait_idle;
    } t_comp_byte;

    typedef struct {
        t_byte data;
        logic  run_last;
        logic  stream_done;
    } t_dec_byte;

    logic i_clk = 1'b0;
    logic i_rst_n;

    blz_in_if  in_if ();
    blz_out_if out_if ();

    backward_lz_decompressor #(
        .WINDOW_DEPTH(WINDOW)
    ) i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_if),
        .o_out  (out_if)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    t_comp_byte pending_bytes[$];
    t_dec_byte  expected_bytes[$];
    int         fail_cnt = 0;
    int         cycle_cnt = 0;

    // decoder shadow state
    t_byte       hist_mem[WINDOW];
    int unsigned wr_ptr;
    int unsigned out_count;
    t_byte       flag_reg;
    logic [3:0]  tokens_left;
    t_phase      dec_phase;
    t_byte       ref_high;

    task automatic store_byte(input t_byte v);
        hist_mem[HIST_AW'(wr_ptr)] = v;
        wr_ptr = (wr_ptr + 1 >= WINDOW) ? 0 : wr_ptr + 1;
        if (out_count < PRODUCED_MAX)
            out_count++;
    endtask

    task automatic next_token();
        flag_reg = flag_reg << 1;
        if (tokens_left != 0)
            tokens_left--;
        dec_phase = (tokens_left != 0) ? PH_TOKEN : PH_FLAG;
    endtask

    task automatic clear_stream();
        dec_phase   = PH_FLAG;
        tokens_left = '0;
        flag_reg    = '0;
        out_count   = 0;
        ref_high    = '0;
    endtask

    // works out the decoded bytes that one compressed byte releases
    task automatic decode_byte(input t_byte b, input logic fin);
        t_byte       run[$];
        int unsigned len;
        int unsigned ref_dist;
        t_byte       v;
        t_dec_byte   e;
        case (dec_phase)
            PH_TOKEN: begin
                if (flag_reg[7]) begin
                    ref_high  = b;
                    dec_phase = PH_REF_LOW;
                end else begin
                    run.push_back(b);
                    store_byte(b);
                    next_token();
                end
            end
            PH_REF_LOW: begin
                len      = ref_high[7:4] + 3;
                ref_dist = {ref_high[3:0], b} + 3;
                for (int i = 0; i < len; i++) begin
                    v = '0;
                    // distances past this stream's output read as zero
                    if (ref_dist <= out_count)
                        v = hist_mem[HIST_AW'((wr_ptr + WINDOW - ref_dist) % WINDOW)];
                    run.push_back(v);
                    store_byte(v);
                end
                next_token();
            end
            default: begin
                flag_reg    = b;
                tokens_left = FLAG_TOKENS;
                dec_phase   = PH_TOKEN;
            end
        endcase
        foreach (run[k]) begin
            e.data        = run[k];
            e.run_last    = (k == run.size() - 1);
            e.stream_done = e.run_last && fin;
            expected_bytes.push_back(e);
        end
        if (fin)
            clear_stream();
    endtask

    task automatic add_byte(input t_byte b, input logic fin, input logic wait_idle);
        t_comp_byte it;
        it.data      = b;
        it.fin       = fin;
        it.wait_idle = wait_idle;
        pending_bytes.push_back(it);
    endtask

    // well-formed token groups with random content, optionally cut short
    task automatic gen_stream(input bit truncate, input bit wait_idle);
        t_comp_byte seq[$];
        t_comp_byte it;
        int         n_tokens;
        int         made;
        int         prod_est;
        int         cut;
        int         len;
        int         dist_val;
        t_byte      flags;
        n_tokens     = $urandom_range(1, 40);
        made         = 0;
        prod_est     = 0;
        it.fin       = 1'b0;
        it.wait_idle = 1'b0;
        while (made < n_tokens) begin
            flags   = t_byte'($urandom);
            it.data = flags;
            seq.push_back(it);
            for (int k = 7; k >= 0 && made < n_tokens; k--) begin
                if (flags[k]) begin
                    len = $urandom_range(3, 18);
                    case ($urandom_range(0, 9))
                        0, 1:    dist_val = $urandom_range(3, 4098);
                        2:       dist_val = $urandom_range(3, 5);
                        default: dist_val = (prod_est >= 3) ? $urandom_range(3, prod_est) : 3;
                    endcase
                    it.data = t_byte'(((len - 3) << 4) | ((dist_val - 3) >> 8));
                    seq.push_back(it);
                    it.data = t_byte'(dist_val - 3);
                    seq.push_back(it);
                    prod_est += len;
                end else begin
                    it.data = t_byte'($urandom);
                    seq.push_back(it);
                    prod_est++;
                end
                made++;
            end
        end
        cut = truncate ? $urandom_range(0, seq.size() - 1) : seq.size() - 1;
        seq[cut].fin       = 1'b1;
        seq[0].wait_idle   = wait_idle;
        for (int i = 0; i <= cut; i++)
            pending_bytes.push_back(seq[i]);
    endtask

    // driver: bursty sender fed from pending_bytes
    t_comp_byte cur_byte;
    int         burst_left;
    int         gap_left;
    logic       next_valid;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
            burst_left = 0;
            gap_left   = 0;
        end else begin
            if (in_if.valid && in_if.ready)
                decode_byte(cur_byte.data, cur_byte.fin);
            if (!(in_if.valid && !in_if.ready)) begin
                next_valid = 1'b0;
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_bytes.size() != 0 &&
                             !(pending_bytes[0].wait_idle &&
                               (expected_bytes.size() != 0 ||
                                (out_if.valid && out_if.ready)))) begin
                    cur_byte = pending_bytes.pop_front();
                    in_if.in_byte    <= cur_byte.data;
                    in_if.final_byte <= cur_byte.fin;
                    next_valid = 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(0, 30);
                        gap_left   = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 8);
                    end
                end
                in_if.valid <= next_valid;
            end
        end
    end

    // monitor and receiver stall pattern
    int          results_seen;
    int          hold_left;
    int          mode_left;
    int          stall_mode;
    logic [31:0] stall_pat;
    logic        next_ready;
    t_dec_byte   want;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
            results_seen = 0;
            hold_left    = 0;
            mode_left    = 0;
            stall_mode   = 0;
            stall_pat    = '1;
        end else begin
            if (out_if.valid && out_if.ready) begin
                if (expected_bytes.size() == 0) begin
                    $display("%0t: unexpected result, expected none, got %02h last=%b done=%b",
                             $time, out_if.out_byte, out_if.run_last, out_if.stream_done);
                    fail_cnt++;
                end else begin
                    want = expected_bytes.pop_front();
                    if (out_if.out_byte !== want.data) begin
                        $display("%0t: out_byte expected %02h, got %02h",
                                 $time, want.data, out_if.out_byte);
                        fail_cnt++;
                    end
                    if (out_if.run_last !== want.run_last) begin
                        $display("%0t: run_last expected %b, got %b",
                                 $time, want.run_last, out_if.run_last);
                        fail_cnt++;
                    end
                    if (out_if.stream_done !== want.stream_done) begin
                        $display("%0t: stream_done expected %b, got %b",
                                 $time, want.stream_done, out_if.stream_done);
                        fail_cnt++;
                    end
                end
                results_seen++;
                // long hold-off so the block backs up into its input
                if (results_seen == 60 || results_seen == 500)
                    hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                next_ready = 1'b0;
            end else begin
                if (mode_left == 0) begin
                    stall_mode = $urandom_range(0, 2);
                    mode_left  = $urandom_range(20, 200);
                    stall_pat  = $urandom;
                end else begin
                    mode_left--;
                end
                case (stall_mode)
                    0: next_ready = 1'b1;
                    1: begin
                        next_ready = stall_pat[0];
                        stall_pat  = {stall_pat[0], stall_pat[31:1]};
                    end
                    default: next_ready = ($urandom_range(0, 3) != 0);
                endcase
            end
            out_if.ready <= next_ready;
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > LIMIT_CYCLES) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        int kind;
        in_if.valid      = 1'b0;
        in_if.in_byte    = '0;
        in_if.final_byte = 1'b0;
        out_if.ready     = 1'b0;
        i_rst_n          = 1'b0;
        wr_ptr           = 0;
        clear_stream();

        // literals at both extremes, overlapping max-length copy,
        // max distance past the output, shortest copy, literal ending the stream
        add_byte(8'h1C, 1'b0, 1'b0);
        add_byte(8'h00, 1'b0, 1'b0);
        add_byte(8'hFF, 1'b0, 1'b0);
        add_byte(8'hA5, 1'b0, 1'b0);
        add_byte(8'hF0, 1'b0, 1'b0);
        add_byte(8'h00, 1'b0, 1'b0);
        add_byte(8'h0F, 1'b0, 1'b0);
        add_byte(8'hFF, 1'b0, 1'b0);
        add_byte(8'h00, 1'b0, 1'b0);
        add_byte(8'h01, 1'b0, 1'b0);
        add_byte(8'h5A, 1'b0, 1'b0);
        add_byte(8'h3C, 1'b1, 1'b0);
        // stream ended on its flag byte, sent once the block has drained
        add_byte(8'h80, 1'b1, 1'b1);
        // stream ended on a reference high byte
        add_byte(8'hFF, 1'b0, 1'b0);
        add_byte(8'h70, 1'b1, 1'b0);
        // reference low byte ends the stream, copy reaches past the output
        add_byte(8'h40, 1'b0, 1'b0);
        add_byte(8'h12, 1'b0, 1'b0);
        add_byte(8'h20, 1'b0, 1'b0);
        add_byte(8'h00, 1'b1, 1'b0);

        kind = pending_bytes.size();
        while (pending_bytes.size() < kind + RANDOM_BYTES) begin
            case ($urandom_range(0, 9))
                0: begin
                    // noise ending in a stream end
                    repeat ($urandom_range(0, 11))
                        add_byte(t_byte'($urandom), 1'b0, 1'b0);
                    add_byte(t_byte'($urandom), 1'b1, 1'b0);
                end
                1:       gen_stream(1'b1, $urandom_range(0, 9) == 0);
                default: gen_stream(1'b0, $urandom_range(0, 9) == 0);
            endcase
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_bytes.size() != 0 || in_if.valid || expected_bytes.size() != 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        if (fail_cnt == 0 && expected_bytes.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
